>>> rtl/core/rcfs_pkg.sv
package rcfs_pkg;

  // stream payload widths
  localparam int unsigned CH_W        = 4;
  localparam int unsigned SAMPLE_W    = 16;
  localparam int unsigned TIME_W      = 32;
  localparam int unsigned VALUE_W     = 12;
  localparam int unsigned IN_TDATA_W  = 56;  // 49 bits used, padded to bytes
  localparam int unsigned OUT_TDATA_W = 16;  // 13 bits used, padded to bytes

  // apb register port
  localparam int unsigned APB_ADDR_W = 6;
  localparam int unsigned APB_DATA_W = 64;
  localparam int unsigned REG_IDX_W  = 3;

  localparam logic [REG_IDX_W-1:0] REG_MODE_BITS    = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_STEPS_LOW    = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_STEPS_HIGH   = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_PULSE_MIN    = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_PULSE_MAX    = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_RANGE_MIN    = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_RANGE_MIDDLE = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_HOLD_TIME    = 3'd7;

  // channel layout
  localparam int unsigned CHANNELS_DEF    = 16;
  localparam int unsigned FLIGHT_CHANNELS = 4;
  localparam int unsigned THROTTLE_INDEX  = 3;

  // failsafe modes
  localparam logic [1:0] MODE_AUTO = 2'd0;
  localparam logic [1:0] MODE_HOLD = 2'd1;
  localparam logic [1:0] MODE_SET  = 2'd2;
  localparam logic [1:0] MODE_PASS = 2'd3;

  // time in ms stays below 2^23; deadline = ms + hold also fits
  localparam int unsigned MS_W          = 23;
  localparam int unsigned DIV_PROD_W    = 61;
  localparam int unsigned DIV_SHIFT     = 38;
  localparam logic [28:0] DIV1000_MAGIC = 29'd274877907;  // ceil(2^38 / 1000)

  localparam logic [4:0] SET_STEP_US = 5'd25;

  // reset values
  localparam logic [31:0]       RST_MODE_BITS    = 32'd1431655680;
  localparam logic [47:0]       RST_STEPS_LOW    = 48'd107228557313560;
  localparam logic [47:0]       RST_STEPS_HIGH   = 48'd107228562556440;
  localparam logic [VALUE_W-1:0] RST_PULSE_MIN   = 12'd885;
  localparam logic [VALUE_W-1:0] RST_PULSE_MAX   = 12'd2115;
  localparam logic [VALUE_W-1:0] RST_RANGE_MIN   = 12'd1000;
  localparam logic [VALUE_W-1:0] RST_RANGE_MIDDLE = 12'd1500;
  localparam logic [15:0]       RST_HOLD_TIME    = 16'd300;
  localparam logic [VALUE_W-1:0] RST_LAST_VALUE  = 12'd1500;
  localparam logic [VALUE_W-1:0] RST_LAST_THROTTLE = 12'd1000;
  localparam logic [MS_W-1:0]   RST_DEADLINE     = 23'd300;

  typedef struct packed {
    logic [31:0]        mode_bits;
    logic [47:0]        steps_low;
    logic [47:0]        steps_high;
    logic [VALUE_W-1:0] pulse_min;
    logic [VALUE_W-1:0] pulse_max;
    logic [VALUE_W-1:0] range_min;
    logic [VALUE_W-1:0] range_middle;
    logic [15:0]        hold_time_ms;
  } cfg_t;

endpackage

>>> rtl/core/rc_channel_failsafe.sv
// rc channel failsafe: takes one receiver channel word per cycle unless the output
// stalls (channel index in tuser, pulse width, signal-present flag and microsecond
// time in tdata) and returns the channel's output after failsafe handling and
// clamping to the pulse limits, plus the running flight-channels-valid flag of the
// frame. Sustained rate is one word per clock while m_axis_tready is held high; a
// word passes through the input register, ms register and output register in that
// order (the ms conversion sits in front of the middle register and the state update
// in front of the output register). The limit is the per-channel state loop: last
// output, hold deadline and frame flag are read and written back in the update
// stage, so consecutive words see each other's effects. Channel 0 opens a frame.
// Configuration sits behind a 64-bit apb port, register i at byte address 8*i; the
// user must write it only while the stream is idle, the block does not enforce this.
module rc_channel_failsafe #(
  parameter int unsigned CHANNELS = rcfs_pkg::CHANNELS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // input stream
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // sample [15:0], signal_present [16], time_us [48:17], zero pad
  input  logic [rcfs_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  // channel [3:0]
  input  logic [rcfs_pkg::CH_W-1:0]          s_axis_tuser,
  // output stream
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // value [11:0], flight_valid [12], zero pad
  output logic [rcfs_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
  // configuration
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [rcfs_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [rcfs_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [rcfs_pkg::APB_DATA_W-1:0]    prdata,
  output logic                               pready
);
  import rcfs_pkg::*;

  localparam int unsigned IDX_W = $clog2(CHANNELS);

  cfg_t cfg;

  rcfs_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // pipeline flow control: every stage advances when the one after it has room
  logic s1_valid_q, s2_valid_q, out_valid_q;
  logic out_take, s2_free, s1_free;

  assign out_take      = !out_valid_q || m_axis_tready;
  assign s2_free       = !s2_valid_q || out_take;
  assign s1_free       = !s1_valid_q || s2_free;
  assign s_axis_tready = s1_free;

  // stage 1: input register
  logic [CH_W-1:0]     s1_ch_q;
  logic [SAMPLE_W-1:0] s1_sample_q;
  logic                s1_sig_q;
  logic [TIME_W-1:0]   s1_time_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_free) begin
      s1_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_free && s_axis_tvalid) begin
      s1_ch_q     <= s_axis_tuser;
      s1_sample_q <= s_axis_tdata[SAMPLE_W-1:0];
      s1_sig_q    <= s_axis_tdata[SAMPLE_W];
      s1_time_q   <= s_axis_tdata[SAMPLE_W+1 +: TIME_W];
    end
  end

  // us to ms: multiply by the scaled reciprocal of 1000, keep the high bits
  logic [DIV_PROD_W-1:0] div_prod;
  logic [MS_W-1:0]       s1_ms;

  assign div_prod = DIV_PROD_W'(s1_time_q) * DIV_PROD_W'(DIV1000_MAGIC);
  assign s1_ms    = div_prod[DIV_SHIFT +: MS_W];

  // stage 2: state read, failsafe decision and write back
  logic [CH_W-1:0]     s2_ch_q;
  logic [SAMPLE_W-1:0] s2_sample_q;
  logic                s2_sig_q;
  logic [MS_W-1:0]     s2_ms_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (s2_free) begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_free && s1_valid_q) begin
      s2_ch_q     <= s1_ch_q;
      s2_sample_q <= s1_sample_q;
      s2_sig_q    <= s1_sig_q;
      s2_ms_q     <= s1_ms;
    end
  end

  // per-channel state
  logic [VALUE_W-1:0] last_value_q [CHANNELS];
  logic [MS_W-1:0]    deadline_q   [CHANNELS];
  logic               frame_valid_q;

  logic               s2_fire;
  logic               in_range;
  logic [IDX_W-1:0]   idx;
  logic [VALUE_W-1:0] last_val;
  logic [MS_W-1:0]    deadline;
  logic [1:0]         mode;
  logic [5:0]         step_lsb;
  logic [5:0]         step;
  logic [VALUE_W:0]   set_val;     // pulse_min + 25 * step, up to 13 bits
  logic               flight;
  logic               throttle;
  logic               fv_start;
  logic               fv_end;
  logic               pulse_ok;
  logic               expired;
  logic [SAMPLE_W-1:0] v;
  logic [VALUE_W-1:0] v_clamp;
  logic [VALUE_W-1:0] res_value;
  logic               res_fv;

  assign s2_fire  = s2_valid_q && out_take;
  assign in_range = {1'b0, s2_ch_q} < (CH_W+1)'(CHANNELS);
  assign idx      = s2_ch_q[IDX_W-1:0];
  assign last_val = last_value_q[idx];
  assign deadline = deadline_q[idx];

  assign mode     = cfg.mode_bits[{s2_ch_q, 1'b0} +: 2];
  // six bits per channel, eight channels to a register
  assign step_lsb = {1'b0, s2_ch_q[2:0], 2'b00} + {2'b00, s2_ch_q[2:0], 1'b0};
  assign step     = s2_ch_q[3] ? cfg.steps_high[step_lsb +: 6]
                               : cfg.steps_low[step_lsb +: 6];
  assign set_val  = {1'b0, cfg.pulse_min}
                  + ((VALUE_W+1)'(step) * (VALUE_W+1)'(SET_STEP_US));

  assign flight   = s2_ch_q < CH_W'(FLIGHT_CHANNELS);
  assign throttle = s2_ch_q == CH_W'(THROTTLE_INDEX);

  // channel 0 reloads the frame flag from signal present
  assign fv_start = (s2_ch_q == '0) ? s2_sig_q : frame_valid_q;
  assign pulse_ok = fv_start
                 && (s2_sample_q >= SAMPLE_W'(cfg.pulse_min))
                 && (s2_sample_q <= SAMPLE_W'(cfg.pulse_max));
  assign expired  = !(s2_ms_q < deadline);

  always_comb begin
    v      = s2_sample_q;
    fv_end = fv_start;
    if (!s2_sig_q) begin
      // signal lost: per-channel failsafe mode
      case (mode)
        MODE_AUTO: begin
          if (throttle) begin
            v = SAMPLE_W'(cfg.range_min);
          end else if (flight) begin
            v = SAMPLE_W'(cfg.range_middle);
          end else begin
            v = SAMPLE_W'(last_val);
          end
        end
        MODE_HOLD: v = SAMPLE_W'(last_val);
        MODE_SET:  v = SAMPLE_W'(set_val);
        MODE_PASS: v = s2_sample_q;
        default:   v = s2_sample_q;
      endcase
    end else if (!pulse_ok) begin
      if (!expired) begin
        v = SAMPLE_W'(last_val);
      end else begin
        // past the hold window: a flight channel drops the whole frame
        if (flight) begin
          fv_end = 1'b0;
        end
        v = (mode == MODE_SET) ? SAMPLE_W'(set_val) : SAMPLE_W'(last_val);
      end
    end
  end

  // floor test wins when the limits are inverted
  always_comb begin
    if (v < SAMPLE_W'(cfg.pulse_min)) begin
      v_clamp = cfg.pulse_min;
    end else if (v > SAMPLE_W'(cfg.pulse_max)) begin
      v_clamp = cfg.pulse_max;
    end else begin
      v_clamp = v[VALUE_W-1:0];
    end
  end

  // channels beyond the table leave state alone and report zero
  assign res_value = in_range ? v_clamp : '0;
  assign res_fv    = in_range ? fv_end : frame_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_valid_q <= 1'b0;
      for (int i = 0; i < CHANNELS; i++) begin
        last_value_q[i] <= (i == THROTTLE_INDEX) ? RST_LAST_THROTTLE : RST_LAST_VALUE;
        deadline_q[i]   <= RST_DEADLINE;
      end
    end else if (s2_fire && in_range) begin
      frame_valid_q     <= fv_end;
      last_value_q[idx] <= v_clamp;
      if (pulse_ok) begin
        deadline_q[idx] <= s2_ms_q + MS_W'(cfg.hold_time_ms);
      end
    end
  end

  // output register
  logic [VALUE_W-1:0] out_value_q;
  logic               out_fv_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_take) begin
      out_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_fire) begin
      out_value_q <= res_value;
      out_fv_q    <= res_fv;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {(OUT_TDATA_W-VALUE_W-1)'(0), out_fv_q, out_value_q};

endmodule

>>> rtl/core/rcfs_regs.sv
module rcfs_regs (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [rcfs_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [rcfs_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [rcfs_pkg::APB_DATA_W-1:0]    prdata,
  output logic                               pready,
  output rcfs_pkg::cfg_t                     cfg_o
);
  import rcfs_pkg::*;

  cfg_t                 cfg_q;
  logic                 wr_en;
  logic [REG_IDX_W-1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite & pready;
  assign reg_idx = paddr[APB_ADDR_W-1 -: REG_IDX_W];  // 8-byte register spacing

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode_bits    <= RST_MODE_BITS;
      cfg_q.steps_low    <= RST_STEPS_LOW;
      cfg_q.steps_high   <= RST_STEPS_HIGH;
      cfg_q.pulse_min    <= RST_PULSE_MIN;
      cfg_q.pulse_max    <= RST_PULSE_MAX;
      cfg_q.range_min    <= RST_RANGE_MIN;
      cfg_q.range_middle <= RST_RANGE_MIDDLE;
      cfg_q.hold_time_ms <= RST_HOLD_TIME;
    end else if (wr_en) begin
      case (reg_idx)
        REG_MODE_BITS:    cfg_q.mode_bits    <= pwdata[31:0];
        REG_STEPS_LOW:    cfg_q.steps_low    <= pwdata[47:0];
        REG_STEPS_HIGH:   cfg_q.steps_high   <= pwdata[47:0];
        REG_PULSE_MIN:    cfg_q.pulse_min    <= pwdata[VALUE_W-1:0];
        REG_PULSE_MAX:    cfg_q.pulse_max    <= pwdata[VALUE_W-1:0];
        REG_RANGE_MIN:    cfg_q.range_min    <= pwdata[VALUE_W-1:0];
        REG_RANGE_MIDDLE: cfg_q.range_middle <= pwdata[VALUE_W-1:0];
        REG_HOLD_TIME:    cfg_q.hold_time_ms <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_MODE_BITS:    prdata = APB_DATA_W'(cfg_q.mode_bits);
      REG_STEPS_LOW:    prdata = APB_DATA_W'(cfg_q.steps_low);
      REG_STEPS_HIGH:   prdata = APB_DATA_W'(cfg_q.steps_high);
      REG_PULSE_MIN:    prdata = APB_DATA_W'(cfg_q.pulse_min);
      REG_PULSE_MAX:    prdata = APB_DATA_W'(cfg_q.pulse_max);
      REG_RANGE_MIN:    prdata = APB_DATA_W'(cfg_q.range_min);
      REG_RANGE_MIDDLE: prdata = APB_DATA_W'(cfg_q.range_middle);
      REG_HOLD_TIME:    prdata = APB_DATA_W'(cfg_q.hold_time_ms);
      default:          prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule
